// ----- rtl/u8u16len_pkg.sv -----
`timescale 1ns / 1ps

package u8u16len_pkg;

  localparam int unsigned RESULT_WIDTH = 32;

  // byte class masks and patterns
  localparam logic [7:0] MASK_TOP1 = 8'h80;
  localparam logic [7:0] MASK_TOP3 = 8'hE0;
  localparam logic [7:0] MASK_TOP4 = 8'hF0;
  localparam logic [7:0] MASK_TOP5 = 8'hF8;
  localparam logic [7:0] PAT_LEAD2 = 8'hC0;
  localparam logic [7:0] PAT_LEAD3 = 8'hE0;
  localparam logic [7:0] PAT_LEAD4 = 8'hF0;
  localparam logic [7:0] MASK_LEAD4_BITS = 8'h07;
  localparam logic [7:0] MASK_FOLLOW_BITS = 8'h3F;
  localparam logic [7:0] FOLLOW_PLANE_MIN = 8'h10;

  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE = 2'd1;
  localparam logic [1:0] NEED_TWO = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

endpackage

// ----- rtl/u8u16len_in_stage.sv -----
`timescale 1ns / 1ps

module u8u16len_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u8u16len_pkg::item_t  in_item,
  input  logic                 advance,
  output logic                 item_valid,
  output u8u16len_pkg::item_t  item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ----- rtl/u8u16len_count.sv -----
`timescale 1ns / 1ps

module u8u16len_count #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     go,
  input  u8u16len_pkg::item_t                      item,
  output logic                                     res_valid,
  output logic [u8u16len_pkg::RESULT_WIDTH-1:0]    res_value
);

  localparam int unsigned RW = u8u16len_pkg::RESULT_WIDTH;

  logic [7:0]             pending_lead, pending_lead_next;
  logic [7:0]             follow0, follow0_next;
  logic [1:0]             bytes_needed, bytes_needed_next;
  logic [1:0]             bytes_collected, bytes_collected_next;
  logic [COUNT_WIDTH-1:0] running_units, running_units_next;

  logic [1:0]             inc_take;
  logic [1:0]             inc_tail;
  logic [1:0]             inc;
  logic                   wide;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_units;

  always_comb begin
    pending_lead_next    = pending_lead;
    follow0_next         = follow0;
    bytes_needed_next    = bytes_needed;
    bytes_collected_next = bytes_collected;
    inc_take             = 2'd0;
    inc_tail             = 2'd0;
    wide                 = 1'b0;

    if (item.has_byte) begin
      if (bytes_needed != u8u16len_pkg::NEED_NONE) begin
        if (bytes_collected == 2'd0) begin
          follow0_next = item.data_byte;
        end
        bytes_collected_next = bytes_collected + 2'd1;
        if (bytes_collected_next >= bytes_needed) begin
          // only a complete 4-byte form above the bmp needs a surrogate pair
          wide = (bytes_needed == u8u16len_pkg::NEED_THREE) &&
                 (((pending_lead & u8u16len_pkg::MASK_LEAD4_BITS) != 8'h00) ||
                  ((follow0 & u8u16len_pkg::MASK_FOLLOW_BITS) >=
                   u8u16len_pkg::FOLLOW_PLANE_MIN));
          inc_take             = wide ? 2'd2 : 2'd1;
          bytes_needed_next    = u8u16len_pkg::NEED_NONE;
          bytes_collected_next = 2'd0;
        end
      end else begin
        pending_lead_next    = item.data_byte;
        bytes_collected_next = 2'd0;
        priority if ((item.data_byte & u8u16len_pkg::MASK_TOP1) == 8'h00) begin
          inc_take = 2'd1;
        end else if ((item.data_byte & u8u16len_pkg::MASK_TOP3) ==
                     u8u16len_pkg::PAT_LEAD2) begin
          bytes_needed_next = u8u16len_pkg::NEED_ONE;
        end else if ((item.data_byte & u8u16len_pkg::MASK_TOP4) ==
                     u8u16len_pkg::PAT_LEAD3) begin
          bytes_needed_next = u8u16len_pkg::NEED_TWO;
        end else if ((item.data_byte & u8u16len_pkg::MASK_TOP5) ==
                     u8u16len_pkg::PAT_LEAD4) begin
          bytes_needed_next = u8u16len_pkg::NEED_THREE;
        end else begin
          inc_take = 2'd1;
        end
      end
    end

    // unfinished sequence at end: lead counts one, buffered bytes re-read as leads
    if (item.last && (bytes_needed_next != u8u16len_pkg::NEED_NONE)) begin
      priority if (bytes_collected_next == 2'd0) begin
        inc_tail = 2'd1;
      end else if (bytes_collected_next == 2'd1) begin
        inc_tail = 2'd2;
      end else if ((follow0_next & u8u16len_pkg::MASK_TOP3) == u8u16len_pkg::PAT_LEAD2) begin
        inc_tail = 2'd2;
      end else begin
        inc_tail = 2'd3;
      end
    end

    // take and tail never both add, so the sum stays within two bits
    inc = inc_take | inc_tail;
    sum = {1'b0, running_units} + {{(COUNT_WIDTH - 1){1'b0}}, inc};
    sat_units = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    running_units_next = sat_units;

    if (item.last) begin
      pending_lead_next    = 8'h00;
      bytes_needed_next    = u8u16len_pkg::NEED_NONE;
      bytes_collected_next = 2'd0;
      running_units_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead    <= 8'h00;
      bytes_needed    <= u8u16len_pkg::NEED_NONE;
      bytes_collected <= 2'd0;
      running_units   <= '0;
    end else if (go) begin
      pending_lead    <= pending_lead_next;
      bytes_needed    <= bytes_needed_next;
      bytes_collected <= bytes_collected_next;
      running_units   <= running_units_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      follow0 <= follow0_next;
    end
  end

  assign res_valid = go && item.last;

  generate
    if (COUNT_WIDTH > RW) begin : g_clip
      assign res_value = (sat_units[COUNT_WIDTH-1:RW] != '0) ? {RW{1'b1}} : sat_units[RW-1:0];
    end else if (COUNT_WIDTH == RW) begin : g_same
      assign res_value = sat_units;
    end else begin : g_ext
      assign res_value = {{(RW - COUNT_WIDTH){1'b0}}, sat_units};
    end
  endgenerate

endmodule

// ----- rtl/u8u16len_out_stage.sv -----
`timescale 1ns / 1ps

module u8u16len_out_stage (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic [u8u16len_pkg::RESULT_WIDTH-1:0] load_value,
  output logic                                  free,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [u8u16len_pkg::RESULT_WIDTH-1:0] out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_value;
    end
  end

endmodule

// ----- rtl/utf8_to_utf16_length_counter.sv -----
`timescale 1ns / 1ps

// channel   dir  tdata                     tuser       tlast
// s_axis    in   [7:0] data_byte           [0] has_byte  last
// m_axis    out  [31:0] unit_total         -           -
//
// one byte per cycle sustained unless a last beat waits for the output register; a beat
// is held in the input register and counted as it leaves; a last beat loads its total into the output register.
// rst is synchronous and clears the sequence state, the count and both valid flags.
// a stalled result holds in the output register; beats without last keep flowing,
// a last beat waits in the input register until the output register is free.

module utf8_to_utf16_length_counter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] unit_total
);

  u8u16len_pkg::item_t in_item;
  u8u16len_pkg::item_t item;
  logic                item_valid;
  logic                advance;
  logic                out_free;
  logic                res_valid;
  logic [31:0]         res_value;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.has_byte  = s_axis_tuser;
  assign in_item.last      = s_axis_tlast;

  // a beat that ends the string needs room for its result
  assign advance = item_valid && (!item.last || out_free);

  u8u16len_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  u8u16len_count #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_count (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (item),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  u8u16len_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (res_valid),
    .load_value (res_value),
    .free       (out_free),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule
